FILE: src/assert_macros.svh
// Assertion macros used by the checker module of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DQS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dqs_pkg.sv
// Package with the widths, codes and types of the deque with value search.
`default_nettype none

package dqs_pkg;

    localparam int DATA_W    = 32;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 4;
    localparam int OCC_W     = 5;
    localparam int DEPTH_DEF = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_RIGHT,
        CELL_LEFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     fb_ins;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

`default_nettype wire

FILE: src/dqs_in_if.sv
// Request channel: request type and value, with valid/ready handshake.
`default_nettype none

interface dqs_in_if;

    logic                                valid;
    logic                                ready;
    logic [dqs_pkg::REQ_W-1:0]           req_type;
    logic signed [dqs_pkg::DATA_W-1:0]   data_in;

    modport source (output valid, output req_type, output data_in, input ready);
    modport sink   (input valid, input req_type, input data_in, output ready);

endinterface

`default_nettype wire

FILE: src/dqs_out_if.sv
// Response channel: popped value, status, position and occupancy, with valid/ready.
`default_nettype none

interface dqs_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [dqs_pkg::DATA_W-1:0]   data_out;
    logic [dqs_pkg::STATUS_W-1:0]        status;
    logic [dqs_pkg::POS_W-1:0]           position;
    logic [dqs_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output data_out, output status, output position,
                    output occupancy, input ready);
    modport sink   (input valid, input data_out, input status, input position,
                    input occupancy, output ready);

endinterface

`default_nettype wire

FILE: src/dqs_cell.sv
// One storage cell of the ring: holds a value or takes it from either neighbor.
`default_nettype none

module dqs_cell (
    input  wire logic                              clk,
    input  wire dqs_pkg::cell_op_t                 op,
    input  wire logic signed [dqs_pkg::DATA_W-1:0] prev_data,
    input  wire logic signed [dqs_pkg::DATA_W-1:0] next_data,
    output logic signed [dqs_pkg::DATA_W-1:0]      data
);

    logic signed [dqs_pkg::DATA_W-1:0] data_reg;
    logic signed [dqs_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        case (op)
            dqs_pkg::CELL_RIGHT: data_next = prev_data;
            dqs_pkg::CELL_LEFT:  data_next = next_data;
            default:             data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: src/dqs_ctrl.sv
// Sequencer of the deque: decodes requests, steers the cell row, builds responses.
`default_nettype none

module dqs_ctrl #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    dqs_in_if.sink                                 req,
    dqs_out_if.source                              rsp,
    input  wire logic signed [dqs_pkg::DATA_W-1:0] head,
    output dqs_pkg::cell_ctl_t                     ctl,
    output logic signed [dqs_pkg::DATA_W-1:0]      ins_data
);

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int SW   = $clog2(DEPTH);

    dqs_pkg::state_t                     state_reg, state_next;
    logic [CNTW-1:0]                     count_reg, count_next;
    logic [SW-1:0]                       step_reg, step_next;
    logic                                found_reg, found_next;
    logic                                out_valid_reg, out_valid_next;
    logic [dqs_pkg::REQ_W-1:0]           req_type_reg, req_type_next;
    logic signed [dqs_pkg::DATA_W-1:0]   data_reg, data_next;
    logic signed [dqs_pkg::DATA_W-1:0]   out_data_reg, out_data_next;
    logic [dqs_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic [dqs_pkg::POS_W-1:0]           out_pos_reg, out_pos_next;

    logic                                accept;
    logic                                full;
    logic                                empty;
    logic                                walk_start;
    logic                                last_step;
    logic [CNTW-1:0]                     step_ext;
    logic [SW+dqs_pkg::POS_W-1:0]        step_wide;
    logic [CNTW+dqs_pkg::OCC_W-1:0]      count_wide;

    assign accept     = req.valid && req.ready;
    assign full       = (count_reg == CNTW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign last_step  = (step_reg == SW'(DEPTH - 1));
    assign step_ext   = CNTW'(step_reg);
    assign step_wide  = {{dqs_pkg::POS_W{1'b0}}, step_reg};
    assign count_wide = {{dqs_pkg::OCC_W{1'b0}}, count_reg};

    // Push back, pop back and search walk the whole ring once.
    assign walk_start = accept &&
                        (((req.req_type == dqs_pkg::REQ_PUSH_BACK) && !full) ||
                         ((req.req_type == dqs_pkg::REQ_POP_BACK) && !empty) ||
                         ((req.req_type == dqs_pkg::REQ_SEARCH) && !empty));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dqs_pkg::ST_IDLE:
            begin
                if (walk_start)
                begin
                    state_next = dqs_pkg::ST_WALK;
                end
            end
            dqs_pkg::ST_WALK:
            begin
                if (last_step)
                begin
                    state_next = dqs_pkg::ST_IDLE;
                end
            end
            default: state_next = dqs_pkg::ST_IDLE;
        endcase
    end

    // Outputs toward the cell row and the channels.
    always_comb
    begin
        ctl.op     = dqs_pkg::CELL_HOLD;
        ctl.fb_ins = 1'b0;
        ins_data   = data_reg;
        req.ready  = 1'b0;
        case (state_reg)
            dqs_pkg::ST_IDLE:
            begin
                req.ready = !out_valid_reg || rsp.ready;
                ins_data  = req.data_in;
                if (accept && (req.req_type == dqs_pkg::REQ_PUSH_FRONT) && !full)
                begin
                    ctl.op = dqs_pkg::CELL_RIGHT;
                end
                else if (accept && (req.req_type == dqs_pkg::REQ_POP_FRONT) && !empty)
                begin
                    ctl.op = dqs_pkg::CELL_LEFT;
                end
            end
            dqs_pkg::ST_WALK:
            begin
                // The ring rotates toward the front; a pushed word enters at the
                // back when the entry after the last stored one passes by.
                ctl.op     = dqs_pkg::CELL_LEFT;
                ctl.fb_ins = (req_type_reg == dqs_pkg::REQ_PUSH_BACK) &&
                             (step_ext == count_reg);
            end
            default: ctl.op = dqs_pkg::CELL_HOLD;
        endcase
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.data_out  = out_data_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.position  = out_pos_reg;
    assign rsp.occupancy = count_wide[dqs_pkg::OCC_W-1:0];

    // Datapath and bookkeeping.
    always_comb
    begin
        count_next      = count_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        req_type_next   = req_type_reg;
        data_next       = data_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;

        if ((state_reg == dqs_pkg::ST_IDLE) && walk_start)
        begin
            step_next     = '0;
            found_next    = 1'b0;
            req_type_next = req.req_type;
            data_next     = req.data_in;
            out_data_next = '0;
            out_pos_next  = '0;
        end
        else if ((state_reg == dqs_pkg::ST_IDLE) && accept)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = '0;
            out_status_next = dqs_pkg::STAT_OK;
            out_pos_next    = '0;
            case (req.req_type)
                dqs_pkg::REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        out_status_next = dqs_pkg::STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                dqs_pkg::REQ_PUSH_BACK: out_status_next = dqs_pkg::STAT_FULL;
                dqs_pkg::REQ_POP_FRONT:
                begin
                    if (empty)
                    begin
                        out_status_next = dqs_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        out_data_next = head;
                        count_next    = count_reg - 1'b1;
                    end
                end
                dqs_pkg::REQ_POP_BACK:  out_status_next = dqs_pkg::STAT_EMPTY;
                dqs_pkg::REQ_SEARCH:    out_status_next = dqs_pkg::STAT_NOT_FOUND;
                default:                out_status_next = dqs_pkg::STAT_OK;
            endcase
        end
        else if (state_reg == dqs_pkg::ST_WALK)
        begin
            step_next = step_reg + 1'b1;
            // The head cell shows the entry at the current step's position.
            if ((req_type_reg == dqs_pkg::REQ_SEARCH) && !found_reg &&
                (step_ext < count_reg) && (head == data_reg))
            begin
                found_next   = 1'b1;
                out_pos_next = step_wide[dqs_pkg::POS_W-1:0];
            end
            if ((req_type_reg == dqs_pkg::REQ_POP_BACK) &&
                (step_ext == count_reg - 1'b1))
            begin
                out_data_next = head;
            end
            if (last_step)
            begin
                out_valid_next  = 1'b1;
                out_status_next = dqs_pkg::STAT_OK;
                if ((req_type_reg == dqs_pkg::REQ_SEARCH) && !found_next)
                begin
                    out_status_next = dqs_pkg::STAT_NOT_FOUND;
                end
                if (req_type_reg == dqs_pkg::REQ_PUSH_BACK)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (req_type_reg == dqs_pkg::REQ_POP_BACK)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqs_pkg::ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        data_reg       <= data_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
    end

endmodule

`default_nettype wire

FILE: src/deque_with_value_search.sv
// Top level of the bounded deque with value search: cell row plus sequencer.
//
//  Channel | Role   | Word
//  --------+--------+------------------------------------------------
//  req     | sink   | req_type, data_in
//  rsp     | source | data_out, status, position, occupancy
//
// Push front, pop front, and every request answered without touching the
// ring (full, empty, unknown type) are answered in the next cycle. Push
// back, pop back and search rotate the ring of cells once, one entry past
// the head cell per cycle. The ring contents are not reset; reset only
// clears the count, the sequencer and the response valid. A stalled response
// holds in its register; a new word is taken only when the sequencer is idle
// and the response register is empty or being read in the same cycle.
`default_nettype none

module deque_with_value_search #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dqs_in_if.sink    req,
    dqs_out_if.source rsp
);

    logic signed [dqs_pkg::DATA_W-1:0] cell_q [DEPTH];
    logic signed [dqs_pkg::DATA_W-1:0] ins_data;
    logic signed [dqs_pkg::DATA_W-1:0] fb_data;
    dqs_pkg::cell_ctl_t                ctl;

    // The last cell refills from the head cell, or from the pushed word.
    assign fb_data = ctl.fb_ins ? ins_data : cell_q[0];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [dqs_pkg::DATA_W-1:0] prev_d;
            logic signed [dqs_pkg::DATA_W-1:0] next_d;

            if (i == 0)
            begin : g_first
                assign prev_d = ins_data;
            end
            else
            begin : g_mid_prev
                assign prev_d = cell_q[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign next_d = fb_data;
            end
            else
            begin : g_mid_next
                assign next_d = cell_q[i+1];
            end

            dqs_cell u_cell (
                .clk       (clk),
                .op        (ctl.op),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_q[i])
            );
        end
    endgenerate

    dqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .head     (cell_q[0]),
        .ctl      (ctl),
        .ins_data (ins_data)
    );

endmodule

`default_nettype wire

FILE: src/dqs_chk.sv
// Port-level checker for the deque, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module dqs_chk #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                rsp_valid,
    input wire logic                                rsp_ready,
    input wire logic signed [dqs_pkg::DATA_W-1:0]   rsp_data_out,
    input wire logic [dqs_pkg::STATUS_W-1:0]        rsp_status,
    input wire logic [dqs_pkg::POS_W-1:0]           rsp_position,
    input wire logic [dqs_pkg::OCC_W-1:0]           rsp_occupancy
);

    localparam logic [dqs_pkg::OCC_W-1:0] DEPTH_OCC = dqs_pkg::OCC_W'(DEPTH);

    // A waiting response keeps its word until it is taken.
    `DQS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out) && $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_occupancy), "response changed while stalled")

    // A rejected push only happens with the store full.
    `DQS_ASSERT_NOW(a_full_occ, rsp_valid && (rsp_status == dqs_pkg::STAT_FULL), rsp_occupancy == DEPTH_OCC, "full status with store not full")

    // A rejected pop only happens with the store empty.
    `DQS_ASSERT_NOW(a_empty_occ, rsp_valid && (rsp_status == dqs_pkg::STAT_EMPTY), rsp_occupancy == '0, "empty status with entries stored")

    // Failed requests carry neither a value nor a position.
    `DQS_ASSERT_NOW(a_fail_clean, rsp_valid && (rsp_status != dqs_pkg::STAT_OK), (rsp_data_out == '0) && (rsp_position == '0), "failed request carries data")

endmodule

bind deque_with_value_search dqs_chk #(
    .DEPTH (DEPTH)
) u_dqs_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_data_out  (rsp.data_out),
    .rsp_status    (rsp.status),
    .rsp_position  (rsp.position),
    .rsp_occupancy (rsp.occupancy)
);

`default_nettype wire

FILE: verif/deque_with_value_search_tb.sv
// Self-checking testbench for the deque with value search.
`timescale 1ns / 1ps

module deque_with_value_search_tb;

    import dqs_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int TARGET_REQS   = 400;
    localparam int HOLD_AT_WORD  = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4 * (DEPTH + 1);
    localparam int WATCHDOG_MAX  = 3000;
    localparam logic [REQ_W-1:0] REQ_CODE_MAX = '1;

    typedef struct {
        logic [REQ_W-1:0]         code;
        logic signed [DATA_W-1:0] value;
        int                       gap;
    } request_t;

    typedef struct {
        logic signed [DATA_W-1:0] data_out;
        logic [STATUS_W-1:0]      status;
        logic [POS_W-1:0]         position;
        logic [OCC_W-1:0]         occupancy;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;

    dqs_in_if  req_ch ();
    dqs_out_if rsp_ch ();

    deque_with_value_search DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    request_t pending_requests[$];
    reply_t   expected_replies[$];

    // Predicted contents of the ring.
    logic signed [DATA_W-1:0] ring_mem[DEPTH];
    int ring_head = 0;
    int ring_fill = 0;

    // Stimulus-side view of the contents, used to steer the sequences.
    int shadow[$];
    int n_counted = 0;
    bit burst_mode = 1'b0;

    int gap_left = 0;
    int n_sent = 0;
    int n_words = 0;
    int errors = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit rx_burst = 1'b0;
    int status_seen[4] = '{0, 0, 0, 0};

    function automatic reply_t deque_apply(input logic [REQ_W-1:0] code,
                                           input logic signed [DATA_W-1:0] value);
        reply_t r;
        int     i;
        int     hit;
        r.data_out = '0;
        r.status   = STAT_OK;
        hit        = 0;
        case (code)
            REQ_PUSH_FRONT:
                if (ring_fill >= DEPTH) r.status = STAT_FULL;
                else
                begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_mem[ring_head] = value;
                    ring_fill++;
                end
            REQ_PUSH_BACK:
                if (ring_fill >= DEPTH) r.status = STAT_FULL;
                else
                begin
                    ring_mem[(ring_head + ring_fill) % DEPTH] = value;
                    ring_fill++;
                end
            REQ_POP_FRONT:
                if (ring_fill == 0) r.status = STAT_EMPTY;
                else
                begin
                    r.data_out = ring_mem[ring_head];
                    ring_head  = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            REQ_POP_BACK:
                if (ring_fill == 0) r.status = STAT_EMPTY;
                else
                begin
                    r.data_out = ring_mem[(ring_head + ring_fill - 1) % DEPTH];
                    ring_fill--;
                end
            REQ_SEARCH:
            begin
                r.status = STAT_NOT_FOUND;
                for (i = ring_fill - 1; i >= 0; i--)
                begin
                    if (ring_mem[(ring_head + i) % DEPTH] == value)
                    begin
                        r.status = STAT_OK;
                        hit = i;
                    end
                end
            end
            default: ;
        endcase
        r.position  = hit[POS_W-1:0];
        r.occupancy = ring_fill[OCC_W-1:0];
        return r;
    endfunction

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 4) - 2;
            1:
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 0;
                    default: return -1;
                endcase
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] search_value();
        if (shadow.size() > 0 && $urandom_range(0, 2) != 0)
            return shadow[$urandom_range(0, shadow.size() - 1)];
        return rand_value();
    endfunction

    task automatic add_request(input logic [REQ_W-1:0] code,
                               input logic signed [DATA_W-1:0] value);
        request_t item;
        item.code  = code;
        item.value = value;
        item.gap   = draw_gap();
        pending_requests.push_back(item);
        case (code)
            REQ_PUSH_FRONT: if (shadow.size() < DEPTH) shadow.push_front(value);
            REQ_PUSH_BACK:  if (shadow.size() < DEPTH) shadow.push_back(value);
            REQ_POP_FRONT:  if (shadow.size() > 0) void'(shadow.pop_front());
            REQ_POP_BACK:   if (shadow.size() > 0) void'(shadow.pop_back());
            default: ;
        endcase
        if (code <= REQ_SEARCH) n_counted++;
    endtask

    task automatic add_push();
        add_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, rand_value());
    endtask

    task automatic add_pop();
        add_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, rand_value());
    endtask

    // Fill to capacity, then push against the full store and search it.
    task automatic run_fill();
        while (shadow.size() < DEPTH)
        begin
            if ($urandom_range(0, 4) == 0) add_request(REQ_SEARCH, search_value());
            else add_push();
        end
        repeat ($urandom_range(1, 3)) add_push();
        repeat (2) add_request(REQ_SEARCH, search_value());
    endtask

    // Drain to empty, then pop the empty store and search it.
    task automatic run_drain();
        while (shadow.size() > 0)
        begin
            if ($urandom_range(0, 4) == 0) add_request(REQ_SEARCH, search_value());
            else add_pop();
        end
        repeat ($urandom_range(1, 2)) add_pop();
        add_request(REQ_SEARCH, search_value());
    endtask

    task automatic run_mixed();
        repeat (20)
        begin
            case ($urandom_range(0, 30))
                0: add_request(REQ_W'($urandom_range(REQ_SEARCH + 1, REQ_CODE_MAX)),
                               $urandom);
                1, 2, 3, 4, 5, 6, 7: add_push();
                8, 9, 10, 11, 12, 13, 14: add_pop();
                default: add_request(REQ_SEARCH, search_value());
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        request_t nxt;
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= REQ_PUSH_FRONT;
            req_ch.data_in  <= '0;
            gap_left        <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_replies.push_back(deque_apply(req_ch.req_type, req_ch.data_in));
                n_sent++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left     <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    nxt              = pending_requests.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= nxt.code;
                    req_ch.data_in  <= nxt.value;
                    gap_left        <= nxt.gap;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : reply_monitor
        reply_t want;
        logic   rdy;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_words++;
                if (expected_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %0h/%0d/%0d/%0d",
                             $time, rsp_ch.data_out, rsp_ch.status, rsp_ch.position,
                             rsp_ch.occupancy);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    status_seen[want.status]++;
                    check_field("data_out", want.data_out, rsp_ch.data_out);
                    check_field("status", DATA_W'(want.status), DATA_W'(rsp_ch.status));
                    check_field("position", DATA_W'(want.position),
                                DATA_W'(rsp_ch.position));
                    check_field("occupancy", DATA_W'(want.occupancy),
                                DATA_W'(rsp_ch.occupancy));
                end
                if (n_words % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
                stall_left = rx_burst ? 0 : $urandom_range(0, 11);
                // One long hold-off lets the block back up onto its input.
                if (n_words == HOLD_AT_WORD) hold_left = HOLD_CYCLES;
            end
            rdy = 1'b1;
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            rsp_ch.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_MAX)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int code;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_PUSH_FRONT;
        req_ch.data_in  = '0;
        rsp_ch.ready    = 1'b0;

        // Directed opening: empty-store cases, ignored codes, extremes, search hits.
        add_request(REQ_POP_FRONT, 32'sh1234_5678);
        add_request(REQ_POP_BACK, -1);
        add_request(REQ_SEARCH, 0);
        for (code = REQ_SEARCH + 1; code <= REQ_CODE_MAX; code++)
            add_request(REQ_W'(code), $urandom);
        add_request(REQ_PUSH_BACK, 32'sh7fff_ffff);
        add_request(REQ_PUSH_FRONT, 32'sh8000_0000);
        add_request(REQ_PUSH_BACK, 0);
        add_request(REQ_PUSH_FRONT, -1);
        add_request(REQ_SEARCH, 32'sh7fff_ffff);
        add_request(REQ_SEARCH, 0);
        add_request(REQ_SEARCH, -1);
        add_request(REQ_SEARCH, 32'sh0001_2345);
        add_request(REQ_POP_BACK, 0);
        add_request(REQ_POP_FRONT, 0);
        add_request(REQ_POP_FRONT, 0);
        add_request(REQ_POP_BACK, 0);
        add_request(REQ_SEARCH, 32'sh8000_0000);

        run_fill();
        while (n_counted < TARGET_REQS)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: run_fill();
                1: run_drain();
                default: run_mixed();
            endcase
        end

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        do
            @(posedge clk);
        while (pending_requests.size() != 0 || req_ch.valid || expected_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Every request that went in must have come back as a word.
        if (expected_replies.size() != 0 || req_ch.valid || n_words != n_sent)
        begin
            errors++;
            $display("%0t: word count mismatch, expected %0d, actual %0d",
                     $time, n_sent, n_words);
        end

        $display("Sent %0d requests and checked %0d words.", n_sent, n_words);
        $display("Outcomes: ok %0d, empty %0d, full %0d, not found %0d.",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
                 status_seen[STAT_NOT_FOUND]);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
